/* rtl/srcp_pkg.sv */
// Shared types, widths and codes for the step result cache policy block.
// No dependencies; every other file of the block but srcp_ram imports this package.
`default_nettype none

package srcp_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int STEP_WIDTH = 32;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int ENTRY_W    = STEP_WIDTH + 1;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 4;

	typedef logic [STEP_WIDTH-1:0]  step_t;
	typedef logic [SLOT_W-1:0]      slot_idx_t;
	typedef logic [CNT_W-1:0]       slot_cnt_t;
	typedef logic [1:0]             action_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	// Register indexes
	localparam cfg_index_t CFG_ENTRIES_IN_USE = 2'd0;
	localparam cfg_index_t CFG_STATIC_MODE    = 2'd1;

	// Action codes; the unused code behaves as a query
	localparam action_t ACT_SELECT = 2'd0;
	localparam action_t ACT_MARK   = 2'd1;
	localparam action_t ACT_QUERY  = 2'd2;

	localparam slot_cnt_t ENTRIES_RESET = slot_cnt_t'(SLOT_COUNT);

	// One slot as stored in memory
	typedef struct packed {
		logic  fresh;
		step_t tag;
	} slot_t;

	typedef struct packed {
		action_t action;
		step_t   step_number;
		logic    mark_value;
	} item_t;

	typedef struct packed {
		slot_idx_t current_slot;
		step_t     current_step;
		logic      is_current_valid;
		logic      step_hit;
	} result_t;

	// Requests from the sequencer to the slot store
	typedef struct packed {
		logic      rd_en;
		slot_idx_t rd_addr;
		logic      wr_en;
		slot_idx_t wr_addr;
		slot_t     wr_data;
	} store_req_t;

endpackage

`default_nettype wire

/* rtl/srcp_if.sv */
// Valid/ready channel interfaces: step input, result output, config write.
// Depends on srcp_pkg for payload types.
`default_nettype none

interface srcp_step_in_if;
	import srcp_pkg::*;
	logic    valid;
	logic    ready;
	action_t action;
	step_t   step_number;
	logic    mark_value;

	modport source (output valid, output action, output step_number, output mark_value,
		input ready);
	modport sink (input valid, input action, input step_number, input mark_value,
		output ready);
endinterface

interface srcp_step_out_if;
	import srcp_pkg::*;
	logic      valid;
	logic      ready;
	slot_idx_t current_slot;
	step_t     current_step;
	logic      is_current_valid;
	logic      step_hit;

	modport source (output valid, output current_slot, output current_step,
		output is_current_valid, output step_hit, input ready);
	modport sink (input valid, input current_slot, input current_step,
		input is_current_valid, input step_hit, output ready);
endinterface

interface srcp_cfg_if;
	import srcp_pkg::*;
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/srcp_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module srcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/srcp_store.sv */
// Slot store: tag/mark RAM plus per-slot valid bits so unwritten slots read as zero.
// Depends on srcp_pkg and srcp_ram.
`default_nettype none

module srcp_store (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire srcp_pkg::store_req_t   req,
	output srcp_pkg::slot_t             rd_data
);
	import srcp_pkg::*;

	logic [SLOT_COUNT-1:0] valid_q;
	logic                  rd_valid_s1;
	logic [ENTRY_W-1:0]    ram_rdata;

	srcp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_addr),
		.wdata (req.wr_data),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (ram_rdata)
	);

	// Track written slots; sample the valid bit alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_s1 <= valid_q[req.rd_addr];
			end
		end
	end

	// Unwritten slots read as the reset value
	assign rd_data = rd_valid_s1 ? slot_t'(ram_rdata) : '0;

endmodule

`default_nettype wire

/* rtl/srcp_ctrl.sv */
// Sequencer: current-slot check, slot scan with farthest-tag victim, write-back, result register.
// Depends on srcp_pkg; drives srcp_store through a store_req_t.
`default_nettype none

module srcp_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire srcp_pkg::item_t       in_item,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output srcp_pkg::result_t          out_item,
	input  wire srcp_pkg::slot_idx_t   last_idx,
	input  wire logic                  single_slot,
	input  wire logic                  static_mode,
	output srcp_pkg::store_req_t       req,
	input  wire srcp_pkg::slot_t       rd_data
);
	import srcp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CUR,
		S_SCAN,
		S_DONE
	} state_t;

	state_t    state_q;
	item_t     item_q;
	slot_idx_t ptr_q;
	slot_idx_t idx_q;
	step_t     far_q;
	slot_idx_t victim_q;
	result_t   res_q;

	logic      tag_match;
	step_t     tag_dist;
	logic      farther;
	slot_idx_t victim_nx;
	logic      scan_last;
	logic      start_scan;
	logic      load_out;
	result_t   cur_res;

	// Compare and distance on the slot just read
	always_comb begin
		tag_match = (rd_data.tag == item_q.step_number);
		if (rd_data.tag >= item_q.step_number) begin
			tag_dist = rd_data.tag - item_q.step_number;
		end else begin
			tag_dist = item_q.step_number - rd_data.tag;
		end
		farther   = (tag_dist > far_q);
		victim_nx = farther ? idx_q : victim_q;
		scan_last = (idx_q == last_idx);
	end

	// Result of an item that ends at the current-slot check
	always_comb begin
		cur_res = '{current_slot: ptr_q, current_step: rd_data.tag,
			is_current_valid: rd_data.fresh, step_hit: 1'b0};
		case (item_q.action)
			ACT_MARK: begin
				cur_res.is_current_valid = item_q.mark_value;
			end
			ACT_SELECT: begin
				if (tag_match) begin
					cur_res.step_hit = 1'b1;
				end else if (single_slot) begin
					cur_res.current_step     = item_q.step_number;
					cur_res.is_current_valid = static_mode & rd_data.fresh;
				end
			end
			default: begin
				cur_res.step_hit = 1'b0;
			end
		endcase
		start_scan = (item_q.action == ACT_SELECT) && !tag_match && !single_slot;
	end

	assign in_ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid || out_ready);

	// Store reads and write-backs
	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				req.rd_en   = in_valid;
				req.rd_addr = ptr_q;
			end
			S_CUR: begin
				req.wr_addr = ptr_q;
				if (item_q.action == ACT_MARK) begin
					req.wr_en   = 1'b1;
					req.wr_data = '{fresh: item_q.mark_value, tag: rd_data.tag};
				end else if (item_q.action == ACT_SELECT && !tag_match) begin
					if (single_slot) begin
						req.wr_en   = 1'b1;
						req.wr_data = '{fresh: static_mode & rd_data.fresh,
							tag: item_q.step_number};
					end else begin
						req.rd_en   = 1'b1;
						req.rd_addr = '0;
					end
				end
			end
			S_SCAN: begin
				if (!tag_match) begin
					if (scan_last) begin
						req.wr_en   = 1'b1;
						req.wr_addr = victim_nx;
						req.wr_data = '{fresh: 1'b0, tag: item_q.step_number};
					end else begin
						req.rd_en   = 1'b1;
						req.rd_addr = idx_q + slot_idx_t'(1);
					end
				end
			end
			default: begin
				req = '0;
			end
		endcase
	end

	// Sequencer state, pointer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ptr_q     <= '0;
			out_valid <= 1'b0;
			out_item  <= '0;
			item_q    <= '0;
			res_q     <= '0;
			idx_q     <= '0;
			far_q     <= '0;
			victim_q  <= '0;
		end else begin
			// Load a finished result, or drop valid once it transfers
			if (load_out) begin
				out_item  <= res_q;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= S_CUR;
					end
				end
				S_CUR: begin
					res_q <= cur_res;
					if (start_scan) begin
						idx_q    <= '0;
						far_q    <= '0;
						victim_q <= '0;
						state_q  <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (tag_match) begin
						ptr_q   <= idx_q;
						res_q   <= '{current_slot: idx_q, current_step: rd_data.tag,
							is_current_valid: rd_data.fresh, step_hit: 1'b1};
						state_q <= S_DONE;
					end else if (scan_last) begin
						ptr_q   <= victim_nx;
						res_q   <= '{current_slot: victim_nx, current_step: item_q.step_number,
							is_current_valid: 1'b0, step_hit: 1'b0};
						state_q <= S_DONE;
					end else begin
						if (farther) begin
							far_q <= tag_dist;
						end
						victim_q <= victim_nx;
						idx_q    <= idx_q + slot_idx_t'(1);
					end
				end
				S_DONE: begin
					// Hold until the output register is free
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/step_result_cache_policy_core.sv */
// Top level of the step result cache policy block: config registers, sequencer, slot store.
// Depends on srcp_pkg, the srcp interfaces, srcp_store and srcp_ctrl.
//
// Usage:
//   step_in  - valid/ready channel carrying action, step_number and mark_value.
//   step_out - valid/ready channel returning one result per item: current_slot,
//              current_step, is_current_valid and step_hit.
//   cfg      - valid/ready write channel; index 0 is entries_in_use, index 1 is
//              static_mode. Always ready; write only while no item is in flight.
// Timing:
//   Mark, query, current-slot hit and single-slot retag are settled at the current-slot
//   check and pass through the result register to the output register. A select that
//   misses the current slot scans the slots in use one RAM read per cycle. One item
//   is worked on at a time; the next item is taken the cycle after the result is loaded.
// Reset:
//   Tags and marks read as zero, the pointer is slot 0, entries_in_use is 8 and
//   static_mode is 0. Per-slot valid bits clear at once; no clearing pass.
// Stall:
//   A stalled step_out holds its result; the block still accepts one more item
//   and parks its finished result until the output register frees up.
`default_nettype none

module step_result_cache_policy_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	srcp_step_in_if.sink    step_in,
	srcp_step_out_if.source step_out,
	srcp_cfg_if.sink        cfg
);
	import srcp_pkg::*;

	slot_cnt_t  entries_in_use_q;
	logic       static_mode_q;
	slot_cnt_t  slots_active;
	slot_idx_t  last_idx;
	logic       single_slot;
	item_t      in_item;
	result_t    out_item;
	store_req_t req;
	slot_t      rd_data;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= ENTRIES_RESET;
			static_mode_q    <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ENTRIES_IN_USE: entries_in_use_q <= slot_cnt_t'(cfg.data);
				CFG_STATIC_MODE:    static_mode_q    <= cfg.data[0];
				default:            static_mode_q    <= static_mode_q;
			endcase
		end
	end

	// Clamp the slot count; static mode forces one slot
	always_comb begin
		if (static_mode_q || entries_in_use_q == '0) begin
			slots_active = slot_cnt_t'(1);
		end else if (entries_in_use_q > slot_cnt_t'(SLOT_COUNT)) begin
			slots_active = slot_cnt_t'(SLOT_COUNT);
		end else begin
			slots_active = entries_in_use_q;
		end
		last_idx    = SLOT_W'(slots_active - slot_cnt_t'(1));
		single_slot = (slots_active == slot_cnt_t'(1));
	end

	assign in_item = '{action: step_in.action, step_number: step_in.step_number,
		mark_value: step_in.mark_value};

	assign step_out.current_slot     = out_item.current_slot;
	assign step_out.current_step     = out_item.current_step;
	assign step_out.is_current_valid = out_item.is_current_valid;
	assign step_out.step_hit         = out_item.step_hit;

	srcp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (step_in.valid),
		.in_ready    (step_in.ready),
		.in_item     (in_item),
		.out_valid   (step_out.valid),
		.out_ready   (step_out.ready),
		.out_item    (out_item),
		.last_idx    (last_idx),
		.single_slot (single_slot),
		.static_mode (static_mode_q),
		.req         (req),
		.rd_data     (rd_data)
	);

	srcp_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	// One item at a time: a transfer closes the input until the result is loaded
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(step_in.valid && step_in.ready) |=> !step_in.ready)
		else $error("input accepted while an item is in flight");

	// Write-backs only happen while an item is being worked on
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> !step_in.ready)
		else $error("slot store written while idle");

	// A cycle either reads or writes the store, never both
	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr_en && req.rd_en))
		else $error("slot store read and write in the same cycle");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for step_result_cache_policy_core: sends item and register-write transfers,
// predicts each result with a cycle-free model of the slot policy and checks every result.
// Depends on srcp_pkg, the srcp channel interfaces and the core RTL.

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srcp_pkg::*;

	// The fourth action code has no meaning and reads as a query
	localparam action_t ACT_SPARE = 2'd3;
	// The slowest correct item is its busy time plus the longest idle gap on each side;
	// the run sends under 900 items, so this limit leaves a wide margin
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 85;

	logic clk = 1'b0;
	logic arst_n;

	srcp_step_in_if  in_ch();
	srcp_step_out_if out_ch();
	srcp_cfg_if      cfg_ch();

	step_result_cache_policy_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_in  (in_ch),
		.step_out (out_ch),
		.cfg      (cfg_ch)
	);

	always #5 clk = ~clk;

	// Predicted slot store, pointer and registers
	step_t     slot_tag [SLOT_COUNT];
	logic      slot_mark [SLOT_COUNT];
	slot_idx_t cur_ptr;
	cfg_data_t entries_reg;
	logic      static_reg;

	result_t pending_reports[$];
	int      mismatches = 0;
	int      items_sent = 0;
	int      selects_sent = 0;
	int      step_hits = 0;
	int      reg_writes = 0;
	bit      steady_flow = 1'b0;
	int      stall_left = 0;

	// Pick an idle gap: mostly none, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Advance the predicted cache by one item and return the result it reports
	function automatic result_t apply_cache_policy(input action_t act, input step_t stp,
			input logic mark);
		int      n;
		int      i;
		int      victim;
		logic    hit;
		logic    found;
		step_t   far;
		step_t   tag_dist;
		result_t r;
		n = int'(entries_reg);
		if (n < 1)
			n = 1;
		if (n > SLOT_COUNT)
			n = SLOT_COUNT;
		if (static_reg)
			n = 1;
		hit = 1'b0;
		if (act == ACT_SELECT) begin
			selects_sent++;
			if (slot_tag[cur_ptr] == stp) begin
				hit = 1'b1;
			end else if (n == 1) begin
				// retag in place, even beyond the slots in use
				slot_tag[cur_ptr] = stp;
				if (!static_reg)
					slot_mark[cur_ptr] = 1'b0;
			end else begin
				found = 1'b0;
				for (i = 0; i < n; i++) begin
					if (!found && slot_tag[i] == stp) begin
						cur_ptr = slot_idx_t'(i);
						found = 1'b1;
					end
				end
				if (found) begin
					hit = 1'b1;
				end else begin
					// evict the farthest tag; strict compare keeps the lowest slot on ties
					far = '0;
					victim = 0;
					for (i = 0; i < n; i++) begin
						tag_dist = (slot_tag[i] > stp) ? slot_tag[i] - stp : stp - slot_tag[i];
						if (tag_dist > far) begin
							far = tag_dist;
							victim = i;
						end
					end
					cur_ptr = slot_idx_t'(victim);
					slot_tag[victim] = stp;
					slot_mark[victim] = 1'b0;
				end
			end
		end else if (act == ACT_MARK) begin
			slot_mark[cur_ptr] = mark;
		end
		if (hit)
			step_hits++;
		r.current_slot = cur_ptr;
		r.current_step = slot_tag[cur_ptr];
		r.is_current_valid = slot_mark[cur_ptr];
		r.step_hit = hit;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [STEP_WIDTH-1:0] want,
			input logic [STEP_WIDTH-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Send one item after a random gap; predict its result at the transfer
	task automatic send_item(input action_t act, input step_t stp, input logic mark);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.step_number <= stp;
		in_ch.mark_value <= mark;
		do @(posedge clk); while (!in_ch.ready);
		pending_reports.push_back(apply_cache_policy(act, stp, mark));
		items_sent++;
	endtask

	// Drop valid and hold until every predicted result has come back
	task automatic drain_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// Write one register while the block is idle
	task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_ENTRIES_IN_USE)
			entries_reg = val;
		else if (idx == CFG_STATIC_MODE)
			static_reg = val[0];
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Reset state: query, spare code, a select of tag zero and mark writes on slot 0
	task automatic test_reset_values();
		send_item(ACT_QUERY, 32'h5A5A_A5A5, 1'b1);
		send_item(ACT_SPARE, '1, 1'b1);
		send_item(ACT_MARK, '0, 1'b1);
		send_item(ACT_SELECT, '0, 1'b0);
		send_item(ACT_MARK, '1, 1'b0);
		drain_results();
	endtask

	// Search hit, eviction with ties and far tags, mark survival
	task automatic test_select_paths();
		send_item(ACT_SELECT, '1, 1'b0);
		send_item(ACT_MARK, '0, 1'b1);
		send_item(ACT_SELECT, 32'h8000_0000, 1'b0);
		send_item(ACT_MARK, '0, 1'b1);
		send_item(ACT_SELECT, 32'h0000_0001, 1'b0);
		send_item(ACT_SELECT, 32'h8000_0000, 1'b0);
		send_item(ACT_SELECT, 32'h0000_0007, 1'b0);
		drain_results();
	endtask

	// Slot count extremes, out-of-range counts, stale pointer and static mode
	task automatic test_register_settings();
		int k;
		// retag five of the zero-tagged slots so the pointer lands high
		for (k = 0; k < 5; k++)
			send_item(ACT_SELECT, 32'hF000_0000 + step_t'(k), 1'b0);
		send_item(ACT_MARK, '0, 1'b1);
		drain_results();
		write_reg(CFG_ENTRIES_IN_USE, cfg_data_t'(1));
		send_item(ACT_SELECT, 32'd77, 1'b0);
		send_item(ACT_SELECT, 32'd77, 1'b0);
		drain_results();
		write_reg(CFG_ENTRIES_IN_USE, cfg_data_t'(2));
		send_item(ACT_SELECT, slot_tag[cur_ptr], 1'b0);
		send_item(ACT_SELECT, 32'd5, 1'b0);
		drain_results();
		write_reg(CFG_ENTRIES_IN_USE, cfg_data_t'(0));
		send_item(ACT_SELECT, 32'd9, 1'b0);
		drain_results();
		write_reg(CFG_ENTRIES_IN_USE, cfg_data_t'(15));
		send_item(ACT_SELECT, 32'hF000_0002, 1'b0);
		drain_results();
		write_reg(CFG_ENTRIES_IN_USE, cfg_data_t'(9));
		write_reg(CFG_STATIC_MODE, cfg_data_t'(1));
		send_item(ACT_MARK, '0, 1'b1);
		send_item(ACT_SELECT, 32'd123, 1'b0);
		send_item(ACT_SELECT, 32'd123, 1'b0);
		drain_results();
		write_reg(CFG_STATIC_MODE, cfg_data_t'(0));
		write_reg(CFG_ENTRIES_IN_USE, cfg_data_t'(SLOT_COUNT));
	endtask

	// Phases of random traffic over a small tag pool so hits and evictions mix
	task automatic test_random_traffic();
		step_t   pool [8];
		step_t   base;
		step_t   stp;
		action_t act;
		int      p;
		int      k;
		int      r;
		cfg_data_t entries;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			steady_flow = (p == 3);
			if (p == 0)
				entries = cfg_data_t'(SLOT_COUNT);
			else if (p == 2)
				entries = cfg_data_t'(1);
			else if ($urandom_range(0, 9) < 7)
				entries = cfg_data_t'($urandom_range(1, SLOT_COUNT));
			else
				entries = cfg_data_t'($urandom_range(0, 15));
			write_reg(CFG_ENTRIES_IN_USE, entries);
			write_reg(CFG_STATIC_MODE, cfg_data_t'(p == 4 || $urandom_range(0, 5) == 0));
			base = step_t'($urandom);
			for (k = 0; k < 8; k++) begin
				if (p == 1)
					pool[k] = k[0] ? '1 - step_t'(k) : step_t'(k);
				else
					pool[k] = base + step_t'($urandom_range(0, 40));
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					act = ACT_SELECT;
				else if (r < 75)
					act = ACT_MARK;
				else if (r < 92)
					act = ACT_QUERY;
				else
					act = ACT_SPARE;
				if ($urandom_range(0, 9) == 0)
					stp = step_t'($urandom);
				else
					stp = pool[$urandom_range(0, 7)];
				// hold the sender until the block has caught up
				if (k == PHASE_ITEMS / 2 && p % 3 == 1)
					drain_results();
				send_item(act, stp, 1'($urandom_range(0, 1)));
			end
		end
		steady_flow = 1'b0;
	endtask

	// Stall the result channel at random
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// Compare each result transfer against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: result with none expected: expected nothing, actual slot %0d step %h",
					$time, out_ch.current_slot, out_ch.current_step);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("current_slot", step_t'(want.current_slot),
					step_t'(out_ch.current_slot));
				check_field("current_step", want.current_step, out_ch.current_step);
				check_field("is_current_valid", step_t'(want.is_current_valid),
					step_t'(out_ch.is_current_valid));
				check_field("step_hit", step_t'(want.step_hit), step_t'(out_ch.step_hit));
			end
		end
	end

	// Bound the run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int i;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_QUERY;
		in_ch.step_number = '0;
		in_ch.mark_value = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_ENTRIES_IN_USE;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		for (i = 0; i < SLOT_COUNT; i++) begin
			slot_tag[i] = '0;
			slot_mark[i] = 1'b0;
		end
		cur_ptr = '0;
		entries_reg = cfg_data_t'(ENTRIES_RESET);
		static_reg = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_select_paths();
		test_register_settings();
		test_random_traffic();

		// let any stray result show up before the verdict
		drain_results();
		repeat (30) @(posedge clk);
		$display("Sent %0d items: %0d selects, %0d of them step hits, across %0d register writes.",
			items_sent, selects_sent, step_hits, reg_writes);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/srcp_pkg.sv
rtl/srcp_if.sv
rtl/srcp_ram.sv
rtl/srcp_store.sv
rtl/srcp_ctrl.sv
rtl/step_result_cache_policy_core.sv
tb/sv/tb.sv
